// File: design/host_extent_parser_macros.svh
// ----------------------------------------------------------------------------
// host_extent_parser_macros : assertion macros for the host extent parser
// Shared forms for same-cycle and next-cycle implications on the clock.
// ----------------------------------------------------------------------------
`ifndef HOST_EXTENT_PARSER_MACROS_SVH
`define HOST_EXTENT_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HEP_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define HEP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/hep_pkg.sv
// ----------------------------------------------------------------------------
// hep_pkg : shared definitions for the host extent parser
// Field widths, character codes, status codes and the character class type.
// ----------------------------------------------------------------------------
package hep_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int OFS_W      = 12;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FLD_W  = STATUS_W + 3 * OFS_W;
   localparam int RSP_DATA_W = ((RSP_FLD_W + 7) / 8) * 8;

   // default longest string length
   localparam int MAX_LEN_DEF = 4096;

   // character codes
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_FOUND    = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   // classification of one byte
   typedef struct packed {
      logic is_zero;
      logic is_host;
      logic is_hex;
      logic is_colon;
      logic is_lbrack;
      logic is_rbrack;
   } char_class_type;

endpackage

// File: design/hep_classify.sv
// ----------------------------------------------------------------------------
// hep_classify : byte classifier
// Sorts one byte into the character classes used by the parser.
// ----------------------------------------------------------------------------
module hep_classify (
   input  logic [hep_pkg::CHAR_W-1:0] char_code,
   output hep_pkg::char_class_type    char_class
);
   import hep_pkg::*;

   logic is_digit;
   logic is_upper;
   logic is_lower;
   logic is_hex_alpha;

   // range checks
   assign is_digit     = (char_code >= CH_DIGIT_0) && (char_code <= CH_DIGIT_9);
   assign is_upper     = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
   assign is_lower     = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);
   assign is_hex_alpha = ((char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_F)) ||
                         ((char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_F));

   // class flags
   always_comb begin
      char_class.is_zero   = (char_code == CH_NUL);
      char_class.is_host   = is_digit || is_upper || is_lower || (char_code == CH_DASH) ||
                             (char_code == CH_DOT) || (char_code == CH_STAR);
      char_class.is_hex    = is_digit || is_hex_alpha;
      char_class.is_colon  = (char_code == CH_COLON);
      char_class.is_lbrack = (char_code == CH_LBRACK);
      char_class.is_rbrack = (char_code == CH_RBRACK);
   end

endmodule

// File: design/hep_core.sv
// ----------------------------------------------------------------------------
// hep_core : parser state and result register
// Advances the scan state by one classified byte per step and loads the
// result register on the terminating byte.
// ----------------------------------------------------------------------------
module hep_core #(
   parameter int MAX_LEN = hep_pkg::MAX_LEN_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  hep_pkg::char_class_type     char_class,
   input  logic                        rsp_tready,
   output logic                        rsp_valid,
   output hep_pkg::status_type         rsp_status,
   output logic [hep_pkg::OFS_W-1:0]   rsp_host_start,
   output logic [hep_pkg::OFS_W-1:0]   rsp_host_end,
   output logic [hep_pkg::OFS_W-1:0]   rsp_stop_offset
);
   import hep_pkg::*;

   localparam int PosW = $clog2(MAX_LEN);
   localparam logic [PosW-1:0] LastPos = PosW'(MAX_LEN - 1);
   localparam logic [PosW-1:0] PosOne  = PosW'(1);
   localparam logic [PosW-1:0] PosZero = '0;

   typedef enum logic [2:0] {
      MODE_START,
      MODE_HOST,
      MODE_IPV6,
      MODE_LEAD_COLON,
      MODE_BR_OPEN,
      MODE_BR_BODY,
      MODE_OK,
      MODE_FAIL
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [PosW-1:0]   colon_pos_ff, colon_pos_in;
   logic              colon_seen_ff, colon_seen_in;
   logic [PosW-1:0]   found_end_ff, found_end_in;
   logic [PosW-1:0]   found_stop_ff, found_stop_in;
   logic              overflow_ff, overflow_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [OFS_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [OFS_W-1:0]  rsp_end_ff, rsp_end_in;
   logic [OFS_W-1:0]  rsp_stop_ff, rsp_stop_in;

   logic [PosW-1:0]        res_start;
   logic [PosW-1:0]        res_end;
   logic [PosW-1:0]        res_stop;
   logic [PosW+OFS_W-1:0]  start_wide;
   logic [PosW+OFS_W-1:0]  end_wide;
   logic [PosW+OFS_W-1:0]  stop_wide;
   logic [PosW-1:0]        host_end_pos;

   // host end while in a hostname run: the colon if one was seen
   assign host_end_pos = colon_seen_ff ? colon_pos_ff : pos_ff;

   // result values for a terminating byte
   always_comb begin
      rsp_status_in = STATUS_NONE;
      res_start     = PosZero;
      res_end       = PosZero;
      res_stop      = PosZero;
      if (overflow_ff) begin
         rsp_status_in = STATUS_TOO_LONG;
      end else begin
         case (mode_ff)
            MODE_HOST: begin
               rsp_status_in = STATUS_FOUND;
               res_end       = host_end_pos;
               res_stop      = host_end_pos;
            end
            MODE_IPV6: begin
               rsp_status_in = STATUS_FOUND;
               res_end       = pos_ff;
               res_stop      = pos_ff;
            end
            MODE_OK: begin
               rsp_status_in = STATUS_FOUND;
               res_end       = found_end_ff;
               res_stop      = found_stop_ff;
               res_start     = found_stop_ff - found_end_ff;
            end
            default: begin
               rsp_status_in = STATUS_NONE;
            end
         endcase
      end
      start_wide   = {{OFS_W{1'b0}}, res_start};
      end_wide     = {{OFS_W{1'b0}}, res_end};
      stop_wide    = {{OFS_W{1'b0}}, res_stop};
      rsp_start_in = start_wide[OFS_W-1:0];
      rsp_end_in   = end_wide[OFS_W-1:0];
      rsp_stop_in  = stop_wide[OFS_W-1:0];
   end

   // next scan state
   always_comb begin
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      colon_pos_in  = colon_pos_ff;
      colon_seen_in = colon_seen_ff;
      found_end_in  = found_end_ff;
      found_stop_in = found_stop_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (step) begin
         if (char_class.is_zero) begin
            // result out, state back to start
            rsp_valid_in  = 1'b1;
            mode_in       = MODE_START;
            pos_in        = PosZero;
            colon_pos_in  = PosZero;
            colon_seen_in = 1'b0;
            found_end_in  = PosZero;
            found_stop_in = PosZero;
            overflow_in   = 1'b0;
         end else if (!overflow_ff) begin
            if (pos_ff >= LastPos) begin
               overflow_in = 1'b1;
            end else begin
               pos_in = pos_ff + PosOne;
               case (mode_ff)
                  MODE_START: begin
                     if (char_class.is_host) begin
                        mode_in = MODE_HOST;
                     end else if (char_class.is_colon) begin
                        mode_in = MODE_LEAD_COLON;
                     end else if (char_class.is_lbrack) begin
                        mode_in = MODE_BR_OPEN;
                     end else begin
                        mode_in       = MODE_FAIL;
                        found_end_in  = PosZero;
                        found_stop_in = PosZero;
                     end
                  end
                  MODE_HOST: begin
                     if (char_class.is_host) begin
                        mode_in = MODE_HOST;
                     end else if (char_class.is_colon) begin
                        if (colon_seen_ff) begin
                           mode_in = MODE_IPV6;
                        end else begin
                           colon_seen_in = 1'b1;
                           colon_pos_in  = pos_ff;
                        end
                     end else begin
                        mode_in       = MODE_OK;
                        found_end_in  = host_end_pos;
                        found_stop_in = host_end_pos;
                     end
                  end
                  MODE_IPV6: begin
                     if (!(char_class.is_hex || char_class.is_colon)) begin
                        mode_in       = MODE_OK;
                        found_end_in  = pos_ff;
                        found_stop_in = pos_ff;
                     end
                  end
                  MODE_LEAD_COLON: begin
                     if (char_class.is_colon) begin
                        mode_in = MODE_IPV6;
                     end else begin
                        mode_in       = MODE_FAIL;
                        found_end_in  = PosZero;
                        found_stop_in = PosZero;
                     end
                  end
                  MODE_BR_OPEN: begin
                     if (char_class.is_rbrack) begin
                        mode_in       = MODE_FAIL;
                        found_end_in  = PosZero;
                        found_stop_in = PosZero;
                     end else begin
                        mode_in = MODE_BR_BODY;
                     end
                  end
                  MODE_BR_BODY: begin
                     if (char_class.is_rbrack) begin
                        mode_in       = MODE_OK;
                        found_end_in  = pos_ff;
                        found_stop_in = pos_ff + PosOne;
                     end
                  end
                  default: begin
                     mode_in = mode_ff;
                  end
               endcase
            end
         end
      end
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_START;
         pos_ff        <= PosZero;
         colon_pos_ff  <= PosZero;
         colon_seen_ff <= 1'b0;
         found_end_ff  <= PosZero;
         found_stop_ff <= PosZero;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         colon_pos_ff  <= colon_pos_in;
         colon_seen_ff <= colon_seen_in;
         found_end_ff  <= found_end_in;
         found_stop_ff <= found_stop_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // result payload loads with each terminating byte
      if (step && char_class.is_zero) begin
         rsp_status_ff <= rsp_status_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_stop_ff   <= rsp_stop_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_host_start  = rsp_start_ff;
   assign rsp_host_end    = rsp_end_ff;
   assign rsp_stop_offset = rsp_stop_ff;

endmodule

// File: design/host_extent_parser.sv
// ----------------------------------------------------------------------------
// host_extent_parser : locate the host part of a host-and-port string
//
//   channel | ports     | direction | contents
//   --------+-----------+-----------+------------------------------------------
//   req     | req_t*    | in        | one string byte, zero ends the string
//   rsp     | rsp_t*    | out       | status, host start, host end, stop offset
//
// One byte per clock sustained while no terminating byte waits; each byte
// passes through the input register, and the result register loads as the
// terminating byte leaves it; the result is valid from that register.
// Only the terminating byte waits on a full result register.
// Reset clears the scan state and both valid flags; no clearing pass.
// ----------------------------------------------------------------------------
module host_extent_parser #(
   parameter int MAX_LEN = hep_pkg::MAX_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] char_code
   input  logic [hep_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [13:2] host_start, [25:14] host_end, [37:26] stop_offset
   output logic [hep_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import hep_pkg::*;

   localparam int PadW = RSP_DATA_W - RSP_FLD_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0] s1_char_ff, s1_char_in;
   logic              req_accept;
   logic              s1_fire;
   char_class_type    char_class;

   status_type        rsp_status;
   logic [OFS_W-1:0]  rsp_host_start;
   logic [OFS_W-1:0]  rsp_host_end;
   logic [OFS_W-1:0]  rsp_stop_offset;

   // input stage handshake: only a terminating byte needs room for a result
   assign s1_fire    = s1_valid_ff && (!char_class.is_zero || !rsp_tvalid || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_char_in  = s1_char_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_tdata[CHAR_W-1:0];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_char_ff <= s1_char_in;
   end

   hep_classify u_classify (
      .char_code  (s1_char_ff),
      .char_class (char_class)
   );

   hep_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (s1_fire),
      .char_class      (char_class),
      .rsp_tready      (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_status      (rsp_status),
      .rsp_host_start  (rsp_host_start),
      .rsp_host_end    (rsp_host_end),
      .rsp_stop_offset (rsp_stop_offset)
   );

   // result packing
   assign rsp_tdata = {{PadW{1'b0}}, rsp_stop_offset, rsp_host_end, rsp_host_start,
                       rsp_status};

endmodule

// File: design/hep_checker.sv
// ----------------------------------------------------------------------------
// hep_checker : port checks for the host extent parser
// Watches the result channel for hold behavior and consistent result fields.
// ----------------------------------------------------------------------------
`include "host_extent_parser_macros.svh"

module hep_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hep_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import hep_pkg::*;

   localparam int StartLo = STATUS_W;
   localparam int EndLo   = STATUS_W + OFS_W;
   localparam int StopLo  = STATUS_W + 2 * OFS_W;

   logic [STATUS_W-1:0] status;
   logic [OFS_W-1:0]    host_start;
   logic [OFS_W-1:0]    host_end;
   logic [OFS_W-1:0]    stop_offset;
   logic [OFS_W-1:0]    end_plus_one;
   logic                pad_clear;

   assign status       = rsp_tdata[STATUS_W-1:0];
   assign host_start   = rsp_tdata[StartLo +: OFS_W];
   assign host_end     = rsp_tdata[EndLo +: OFS_W];
   assign stop_offset  = rsp_tdata[StopLo +: OFS_W];
   assign end_plus_one = host_end + OFS_W'(1);
   assign pad_clear    = (rsp_tdata >> RSP_FLD_W) == '0;

   // a stalled transaction holds its payload
   `HEP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // padding bits above the packed fields stay zero
   `HEP_ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, pad_clear, "result padding not zero")

   // failure and too-long results carry no offsets
   `HEP_ASSERT_IMPL(a_rsp_no_host, clock, reset, rsp_tvalid && (status != STATUS_FOUND), (host_start == '0) && (host_end == '0) && (stop_offset == '0), "offsets set without a host")

   // a found host starts at 0 (stop at host end) or at 1 (stop past the bracket)
   `HEP_ASSERT_IMPL(a_rsp_extent, clock, reset, rsp_tvalid && (status == STATUS_FOUND), ((host_start == '0) && (stop_offset == host_end)) || ((host_start == OFS_W'(1)) && (stop_offset == end_plus_one)), "inconsistent host extent")

endmodule

bind host_extent_parser hep_checker u_hep_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
